FILE: sv/ueravg_pkg.sv
// shared types and constants for the ultrasonic echo ranger with averaging filter
package ueravg_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CM_SCALE      = 2'd3;

    // configuration field widths
    localparam int TRIG_W  = 8;
    localparam int LIMIT_W = 16;
    localparam int SCALE_W = 12;

    // configuration reset values
    localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 8'd10;
    localparam logic [LIMIT_W-1:0] RISE_LIMIT_RST    = 16'd30000;
    localparam logic [LIMIT_W-1:0] FALL_LIMIT_RST    = 16'd60000;
    localparam logic [SCALE_W-1:0] CM_SCALE_RST      = 12'd1114;

    // pulse width saturates at 16 bits before scaling
    localparam int                 PW_SAT_W = 16;
    localparam logic [PW_SAT_W-1:0] PW_SAT  = 16'hFFFF;

    // width * scale accumulator, distance is its Q8 integer part
    localparam int ACC_W       = PW_SAT_W + SCALE_W;
    localparam int SCALE_SHIFT = 8;
    localparam int DIST_W      = 20;

    // one result transaction
    typedef struct packed {
        logic              trigger_level;
        logic              done_res;
        logic              timed_out;
        logic [DIST_W-1:0] distance_avg;
    } t_result;

endpackage

FILE: sv/ultrasonic_echo_ranger_avg.sv
// top level: echo pulse rangefinder sequencer with moving average and output skid buffer
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------------------
//  in       | i_valid / o_stall           | i_start_req, i_echo_level
//  out      | o_valid / i_stall           | o_trigger_level, o_done_res, o_timed_out,
//           |                             | o_distance_avg
//  cfg      | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  one input transaction (one tick sample) per cycle while o_stall is low; its result is registered
//  the running sum update and the divide by FILTER_DEPTH are combinational, in the same cycle as the transaction
//  width times scale is re-registered every cycle, so a scale write counts at once
//  synchronous active-low reset clears phase, counters, the ring, its running sum and output registers
//  a two-entry output buffer (output register plus skid) lets input take one more transaction
//  after out stalls; o_stall is high only while the skid entry is occupied
module ultrasonic_echo_ranger_avg #(
    parameter int FILTER_DEPTH = 5,
    parameter int COUNT_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_start_req,
    input  logic                                i_echo_level,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_trigger_level,
    output logic                                o_done_res,
    output logic                                o_timed_out,
    output logic [ueravg_pkg::DIST_W-1:0]       o_distance_avg,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ueravg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ueravg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ueravg_pkg::*;

    localparam int SLOT_W    = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int SUM_W     = DIST_W + $clog2(FILTER_DEPTH);
    localparam int CMP_W     = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    // divide by FILTER_DEPTH as multiply by a rounded-up reciprocal
    localparam int DIV_SHIFT = SUM_W + $clog2(FILTER_DEPTH);
    localparam int RECIP_W   = SUM_W + 2;
    localparam int DPROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH));
    localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(FILTER_DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_RISE,
        PH_HIGH
    } t_phase;

    // count reached limit, with the limit clamped to the counter range
    function automatic logic limit_reached(input logic [COUNT_BITS-1:0] cnt,
                                           input logic [LIMIT_W-1:0]    lim);
        limit_reached = (CMP_W'(cnt) >= CMP_W'(lim)) || (cnt == CNT_MAX);
    endfunction

    // configuration registers
    logic [TRIG_W-1:0]  r_trigger_ticks;
    logic [LIMIT_W-1:0] r_rise_limit;
    logic [LIMIT_W-1:0] r_fall_limit;
    logic [SCALE_W-1:0] r_cm_scale;

    // measurement state
    t_phase                r_phase,  n_phase;
    logic [COUNT_BITS-1:0] r_wait,   n_wait;
    logic [COUNT_BITS-1:0] r_pulse,  n_pulse;
    logic [ACC_W-1:0]      r_acc,    n_acc;
    logic [DIST_W-1:0]     r_hist [FILTER_DEPTH];
    logic [SLOT_W-1:0]     r_slot,   n_slot;
    logic [SUM_W-1:0]      r_sum,    n_sum;
    logic                  n_push;

    // output buffer
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    logic              in_take;
    logic              out_take;
    logic              out_free;
    logic [DIST_W-1:0] scaled;
    logic [SUM_W-1:0]  sum_push;
    logic [DPROD_W-1:0] div_prod;
    t_result           n_result;
    logic [SCALE_W-1:0]    scale_next;
    logic [COUNT_BITS-1:0] pulse_next;
    logic [PW_SAT_W-1:0]   pulse_sat;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skid_valid;
    assign in_take     = i_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_stall;
    assign out_free    = !r_out_valid || out_take;

    // ring update and mean
    assign scaled   = r_acc[SCALE_SHIFT +: DIST_W];
    assign sum_push = r_sum - SUM_W'(r_hist[r_slot]) + SUM_W'(scaled);
    assign div_prod = DPROD_W'(sum_push) * DPROD_W'(DIV_RECIP);

    // phase sequencer for one tick
    always_comb begin
        n_phase  = r_phase;
        n_wait   = r_wait;
        n_pulse  = r_pulse;
        n_push   = 1'b0;
        n_result = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_phase = PH_TRIG;
                    n_wait  = '0;
                end
            end
            PH_TRIG: begin
                n_result.trigger_level = 1'b1;
                if (r_wait != CNT_MAX) begin
                    n_wait = r_wait + 1'b1;
                end
                if (limit_reached(n_wait, LIMIT_W'(r_trigger_ticks))) begin
                    n_phase = PH_RISE;
                    n_wait  = '0;
                end
            end
            PH_RISE: begin
                if (i_echo_level) begin
                    n_phase = PH_HIGH;
                    n_pulse = COUNT_BITS'(1);
                end else if (limit_reached(r_wait, r_rise_limit)) begin
                    n_phase            = PH_IDLE;
                    n_result.done_res  = 1'b1;
                    n_result.timed_out = 1'b1;
                end else begin
                    n_wait = r_wait + 1'b1;
                end
            end
            PH_HIGH: begin
                if (i_echo_level) begin
                    if (limit_reached(r_pulse, r_fall_limit)) begin
                        n_phase            = PH_IDLE;
                        n_result.done_res  = 1'b1;
                        n_result.timed_out = 1'b1;
                    end else begin
                        n_pulse = r_pulse + 1'b1;
                    end
                end else begin
                    n_phase               = PH_IDLE;
                    n_push                = 1'b1;
                    n_result.done_res     = 1'b1;
                    n_result.distance_avg = div_prod[DIV_SHIFT +: DIST_W];
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // scale as it stands after this edge
    always_comb begin
        scale_next = r_cm_scale;
        if (i_cfg_valid && (i_cfg_index == CFG_CM_SCALE)) begin
            scale_next = i_cfg_data[SCALE_W-1:0];
        end
    end

    // saturated pulse width times scale, for the width and scale after this edge
    assign pulse_next = in_take ? n_pulse : r_pulse;
    assign pulse_sat  = (CMP_W'(pulse_next) > CMP_W'(PW_SAT)) ? PW_SAT
                                                              : PW_SAT_W'(pulse_next);
    assign n_acc      = ACC_W'(pulse_sat) * ACC_W'(scale_next);

    // ring write pointer and running sum
    always_comb begin
        n_slot = r_slot;
        n_sum  = r_sum;
        if (n_push) begin
            n_sum  = sum_push;
            n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
        end
    end

    // state, configuration and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= TRIGGER_TICKS_RST;
            r_rise_limit    <= RISE_LIMIT_RST;
            r_fall_limit    <= FALL_LIMIT_RST;
            r_cm_scale      <= CM_SCALE_RST;
            r_phase         <= PH_IDLE;
            r_wait          <= '0;
            r_pulse         <= '0;
            r_acc           <= '0;
            r_slot          <= '0;
            r_sum           <= '0;
            for (int i = 0; i < FILTER_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_out_valid     <= 1'b0;
            r_out           <= '0;
            r_skid_valid    <= 1'b0;
            r_skid          <= '0;
        end else begin
            // configuration write transaction
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TRIGGER_TICKS: r_trigger_ticks <= i_cfg_data[TRIG_W-1:0];
                    CFG_RISE_LIMIT:    r_rise_limit    <= i_cfg_data[LIMIT_W-1:0];
                    CFG_FALL_LIMIT:    r_fall_limit    <= i_cfg_data[LIMIT_W-1:0];
                    CFG_CM_SCALE:      r_cm_scale      <= i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end

            // scaled width follows both the pulse count and the scale
            r_acc <= n_acc;

            // input transaction advances the measurement
            if (in_take) begin
                r_phase <= n_phase;
                r_wait  <= n_wait;
                r_pulse <= n_pulse;
                r_slot  <= n_slot;
                r_sum   <= n_sum;
                if (n_push) begin
                    r_hist[r_slot] <= scaled;
                end
            end

            // output register and skid entry
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_take;
                    if (in_take) begin
                        r_out <= n_result;
                    end
                end
            end else if (in_take) begin
                r_skid       <= n_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

    // result ports
    assign o_valid         = r_out_valid;
    assign o_trigger_level = r_out.trigger_level;
    assign o_done_res      = r_out.done_res;
    assign o_timed_out     = r_out.timed_out;
    assign o_distance_avg  = r_out.distance_avg;

endmodule
